>>> design/pfpn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfpn_pkg
// Shared types, constants and arithmetic steps of the plane normalizer.
// ----------------------------------------------------------------------------
package pfpn_pkg;

   // request kinds
   localparam logic [1:0] MODE_DIST  = 2'd0;
   localparam logic [1:0] MODE_POINT = 2'd1;
   localparam logic [1:0] MODE_TRI   = 2'd2;
   localparam logic [1:0] MODE_NONE  = 2'd3;

   localparam int UNIT_W     = 32;   // Q1.30 unit normal
   localparam int UNIT_FRAC  = 30;
   localparam int MAG_W      = 31;   // magnitude of a reduced normal component
   localparam int SQ_W       = 61;   // square of a reduced component
   localparam int SUM_W      = 62;   // sum of three squares
   localparam int REM_W      = 62;   // divider remainder
   localparam int QUO_W      = 61;   // divider quotient
   localparam int ROOT_W     = 62;   // square root working width
   localparam int DIV_STEPS  = 61;
   localparam int SQRT_STEPS = 31;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   typedef struct packed {
      logic [2:0][SQ_W-1:0] sq;
      logic [SUM_W-1:0]     ssum;
      logic [2:0]           neg;
      logic                 degen;
      logic                 use_dist;
   } pfpn_norm_type;

   // one restoring division step: returns {quotient bit, new remainder}
   function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0] rem,
                                               input logic [SUM_W-1:0] den);
      logic [REM_W:0] wide;
      logic [REM_W:0] res;
      wide = {rem, 1'b0};
      if (wide >= {1'b0, den}) begin
         res = {1'b1, REM_W'(wide - {1'b0, den})};
      end else begin
         res = {1'b0, wide[REM_W-1:0]};
      end
      return res;
   endfunction

   // one square root digit step: returns {new remainder, new root}
   function automatic logic [2*ROOT_W-1:0] sqrt_step(input logic [ROOT_W-1:0] x,
                                                     input logic [ROOT_W-1:0] root,
                                                     input logic [ROOT_W-1:0] wt);
      logic [ROOT_W-1:0] trial;
      logic [2*ROOT_W-1:0] res;
      trial = root + wt;
      if (x >= trial) begin
         res = {x - trial, (root >> 1) + wt};
      end else begin
         res = {x, root >> 1};
      end
      return res;
   endfunction

endpackage
`default_nettype wire

>>> design/plane_from_points_normalizer.sv
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one word per cycle unless stalled; the divider (61 stages)
//   and root (31 stages) are fully pipelined, one quotient or root bit per stage.
// A 4-entry queue parts the front stages from the back; either side stalls alone.
// Reset: synchronous, active high; clears all valid bits and queue pointers.
// ----------------------------------------------------------------------------
// plane_from_points_normalizer
// Plane in normal-distance form from a normal and a distance, a normal and a
// point, or three points. Emits the Q1.30 unit normal and a Q16.16 distance.
// ----------------------------------------------------------------------------
module plane_from_points_normalizer
   import pfpn_pkg::*;
#(
   parameter int COORD_WIDTH = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // vec_a_x, vec_a_y, vec_a_z, vec_b_x, vec_b_y, vec_b_z,
   // vec_c_x, vec_c_y, vec_c_z, in_distance
   input  wire logic [((10*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   // req_type
   input  wire logic [1:0]                        req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // unit_x, unit_y, unit_z, plane_distance
   output logic [((3*UNIT_W+COORD_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // degenerate
   output logic                                   rsp_tuser
);
   localparam int CW    = COORD_WIDTH;
   localparam int OUT_W = ((3*UNIT_W + CW + 7) / 8) * 8;

   logic [2:0][CW-1:0]      vec_a, vec_b, vec_c;
   logic [CW-1:0]           in_distance;
   logic                    job_valid, job_ready, q_full, q_not_empty, q_pop;
   pfpn_norm_type           job_norm, head_norm;
   logic [3:0][CW-1:0]      job_geo, head_geo;
   logic [2:0][UNIT_W-1:0]  unit;
   logic [CW-1:0]           plane_distance;

   // unpack the request word, lowest field first
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vec_a[i] = req_tdata[i*CW +: CW];
         vec_b[i] = req_tdata[(3+i)*CW +: CW];
         vec_c[i] = req_tdata[(6+i)*CW +: CW];
      end
      in_distance = req_tdata[9*CW +: CW];
   end

   // front: differences, cross product, reduction to 31 bits, squares
   pfpn_front #(.CW(CW)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_mode   (req_tuser),
      .in_a      (vec_a),
      .in_b      (vec_b),
      .in_c      (vec_c),
      .in_dist   (in_distance),
      .out_valid (job_valid),
      .out_ready (job_ready),
      .out_norm  (job_norm),
      .out_geo   (job_geo)
   );

   // push only when there is room; the front holds its last stage otherwise
   assign job_ready = !q_full;

   pfpn_queue #(.GW(4*CW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_valid && job_ready),
      .push_norm (job_norm),
      .push_geo  (job_geo),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_norm (head_norm),
      .head_geo  (head_geo)
   );

   // back: divide, root, sign, distance, saturate; owns the result register
   pfpn_back #(.CW(CW)) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_not_empty),
      .in_pop    (q_pop),
      .in_norm   (head_norm),
      .in_geo    (head_geo),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_unit  (unit),
      .rsp_dist  (plane_distance),
      .rsp_degen (rsp_tuser)
   );

   // pack the result word, zero filled to whole bytes
   assign rsp_tdata = OUT_W'({plane_distance, unit[2], unit[1], unit[0]});

endmodule
`default_nettype wire

>>> design/pfpn_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfpn_front
// Accept requests, build the raw normal, reduce it and square its components.
// ----------------------------------------------------------------------------
module pfpn_front
   import pfpn_pkg::*;
#(
   parameter int CW = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire logic [1:0]               in_mode,
   input  wire logic [2:0][CW-1:0]       in_a,
   input  wire logic [2:0][CW-1:0]       in_b,
   input  wire logic [2:0][CW-1:0]       in_c,
   input  wire logic [CW-1:0]            in_dist,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output pfpn_norm_type                 out_norm,
   output logic [3:0][CW-1:0]            out_geo
);
   localparam int DW = CW + 1;
   localparam int PW = 2 * DW;
   localparam int NW = PW + 1;
   localparam int NC = (NW + 7) / 8;
   localparam int LW = $clog2(NC * 8 + 1);
   localparam int KW = $clog2(NW + 1);

   logic adv;
   logic [8:0] vld_ff;

   logic [1:0]               mode0_ff, mode1_ff, mode2_ff;
   logic [2:0][CW-1:0]       a0_ff, b0_ff, c0_ff, a1_ff, a2_ff;
   logic [CW-1:0]            d0_ff;
   logic signed [DW-1:0]     e1_ff [3];
   logic signed [DW-1:0]     f1_ff [3];
   logic signed [PW-1:0]     prod2_ff [6];
   logic signed [NW-1:0]     n3_ff [3];
   logic signed [NW-1:0]     n4_ff [3];
   logic signed [NW-1:0]     n5_ff [3];
   logic [NC-1:0]            nz4_ff;
   logic [2:0]               hib4_ff [NC];
   logic [KW-1:0]            k5_ff;
   logic [MAG_W-1:0]         mag6_ff [3];
   logic [2:0]               neg6_ff, neg7_ff;
   logic [2:0][SQ_W-1:0]     sq7_ff;
   logic [3:0][CW-1:0]       geo_ff [1:8];
   logic [8:3]               degen_ff;
   logic [8:3]               usedist_ff;
   pfpn_norm_type            norm8_ff;

   logic signed [DW-1:0]     e_in [3];
   logic signed [DW-1:0]     f_in [3];
   logic [3:0][CW-1:0]       geo1_in;
   logic signed [PW-1:0]     prod_in [6];
   logic signed [NW-1:0]     n_in [3];
   logic                     degen_in;
   logic [NW-1:0]            mag_or;
   logic [NC*8-1:0]          mag_pad;
   logic [NC-1:0]            nz_in;
   logic [2:0]               hib_in [NC];
   logic [LW-1:0]            len_in;
   logic [KW-1:0]            k_in;
   logic signed [NW-1:0]     shifted;
   logic [MAG_W-1:0]         m_low;
   logic [MAG_W-1:0]         mag_in [3];
   logic [2:0]               neg_in;
   logic [2:0][SQ_W-1:0]     sq_in;
   pfpn_norm_type            norm_in;

   // stall the whole front only when a finished job cannot enter the queue
   assign adv       = !vld_ff[8] || out_ready;
   assign in_ready  = adv;
   assign out_valid = vld_ff[8];
   assign out_norm  = norm8_ff;
   assign out_geo   = geo_ff[8];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e_in[i] = $signed({b0_ff[i][CW-1], b0_ff[i]}) - $signed({a0_ff[i][CW-1], a0_ff[i]});
         f_in[i] = $signed({c0_ff[i][CW-1], c0_ff[i]}) - $signed({a0_ff[i][CW-1], a0_ff[i]});
      end
      geo1_in[3] = d0_ff;
      for (int i = 0; i < 3; i++) begin
         geo1_in[i] = (mode0_ff == MODE_TRI) ? a0_ff[i] : b0_ff[i];
      end
   end

   always_comb begin
      prod_in[0] = e1_ff[1] * f1_ff[2];
      prod_in[1] = e1_ff[2] * f1_ff[1];
      prod_in[2] = e1_ff[2] * f1_ff[0];
      prod_in[3] = e1_ff[0] * f1_ff[2];
      prod_in[4] = e1_ff[0] * f1_ff[1];
      prod_in[5] = e1_ff[1] * f1_ff[0];
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (mode2_ff == MODE_TRI) begin
            n_in[i] = $signed({prod2_ff[2*i][PW-1], prod2_ff[2*i]})
                    - $signed({prod2_ff[2*i+1][PW-1], prod2_ff[2*i+1]});
         end else begin
            n_in[i] = $signed({{(NW-CW){a2_ff[i][CW-1]}}, a2_ff[i]});
         end
      end
      degen_in = (mode2_ff == MODE_NONE)
              || (n_in[0] == '0 && n_in[1] == '0 && n_in[2] == '0);
   end

   // leading bit search, first per byte
   always_comb begin
      mag_or = '0;
      for (int i = 0; i < 3; i++) begin
         mag_or = mag_or | (n3_ff[i] ^ {NW{n3_ff[i][NW-1]}});
      end
      mag_pad = (NC*8)'(mag_or);
      for (int c = 0; c < NC; c++) begin
         nz_in[c]  = |mag_pad[c*8 +: 8];
         hib_in[c] = '0;
         for (int b = 0; b < 8; b++) begin
            if (mag_pad[c*8 + b]) hib_in[c] = 3'(b);
         end
      end
   end

   // then across bytes, and turn the bit length into a right shift
   always_comb begin
      len_in = '0;
      for (int c = 0; c < NC; c++) begin
         if (nz4_ff[c]) len_in = LW'(c * 8) + LW'(hib4_ff[c]) + LW'(1);
      end
      if (len_in > LW'(UNIT_FRAC)) begin
         k_in = KW'(len_in - LW'(UNIT_FRAC));
      end else begin
         k_in = '0;
      end
   end

   always_comb begin
      shifted = '0;
      m_low   = '0;
      for (int i = 0; i < 3; i++) begin
         shifted   = n5_ff[i] >>> k5_ff;
         m_low     = shifted[MAG_W-1:0];
         neg_in[i] = m_low[MAG_W-1];
         mag_in[i] = neg_in[i] ? (MAG_W'(0) - m_low) : m_low;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = SQ_W'(mag6_ff[i] * mag6_ff[i]);
      end
      norm_in.sq       = sq7_ff;
      norm_in.ssum     = SUM_W'(sq7_ff[0]) + SUM_W'(sq7_ff[1]) + SUM_W'(sq7_ff[2]);
      norm_in.neg      = neg7_ff;
      norm_in.degen    = degen_ff[7];
      norm_in.use_dist = usedist_ff[7];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[7:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mode0_ff <= in_mode;
         a0_ff    <= in_a;
         b0_ff    <= in_b;
         c0_ff    <= in_c;
         d0_ff    <= in_dist;
         e1_ff    <= e_in;
         f1_ff    <= f_in;
         a1_ff    <= a0_ff;
         mode1_ff <= mode0_ff;
         geo_ff[1] <= geo1_in;
         prod2_ff <= prod_in;
         a2_ff    <= a1_ff;
         mode2_ff <= mode1_ff;
         n3_ff    <= n_in;
         degen_ff[3]   <= degen_in;
         usedist_ff[3] <= (mode2_ff == MODE_DIST);
         n4_ff    <= n3_ff;
         nz4_ff   <= nz_in;
         hib4_ff  <= hib_in;
         n5_ff    <= n4_ff;
         k5_ff    <= k_in;
         mag6_ff  <= mag_in;
         neg6_ff  <= neg_in;
         sq7_ff   <= sq_in;
         neg7_ff  <= neg6_ff;
         norm8_ff <= norm_in;
         for (int s = 2; s <= 8; s++) geo_ff[s] <= geo_ff[s-1];
         for (int s = 4; s <= 8; s++) begin
            degen_ff[s]   <= degen_ff[s-1];
            usedist_ff[s] <= usedist_ff[s-1];
         end
      end
   end

endmodule
`default_nettype wire

>>> design/pfpn_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfpn_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module pfpn_queue
   import pfpn_pkg::*;
#(
   parameter int GW = 128
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire pfpn_norm_type   push_norm,
   input  wire logic [GW-1:0]   push_geo,
   output logic                 full,
   input  wire logic            pop,
   output logic                 not_empty,
   output pfpn_norm_type        head_norm,
   output logic [GW-1:0]        head_geo
);
   pfpn_norm_type        norm_mem_ff [QUEUE_DEPTH];
   logic [GW-1:0]        geo_mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, rd_ptr_ff, wr_ptr_in, rd_ptr_in;
   logic [QPTR_W:0]      count_ff, count_in;

   assign full      = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_norm = norm_mem_ff[rd_ptr_ff];
   assign head_geo  = geo_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         norm_mem_ff[wr_ptr_ff] <= push_norm;
         geo_mem_ff[wr_ptr_ff]  <= push_geo;
      end
   end

endmodule
`default_nettype wire

>>> design/pfpn_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfpn_back
// Divide, take roots, apply signs and form the distance; hold the result word.
// ----------------------------------------------------------------------------
module pfpn_back
   import pfpn_pkg::*;
#(
   parameter int CW = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_pop,
   input  wire pfpn_norm_type        in_norm,
   input  wire logic [3:0][CW-1:0]   in_geo,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [2:0][UNIT_W-1:0]    rsp_unit,
   output logic [CW-1:0]             rsp_dist,
   output logic                      rsp_degen
);
   localparam int PRW = CW + UNIT_W;
   localparam int AW  = CW + UNIT_W + 2;
   localparam int MW  = AW - UNIT_FRAC;
   localparam logic [MW-1:0] DMAX = MW'((64'd1 << (CW - 1)) - 64'd1);

   typedef struct packed {
      logic [3:0][CW-1:0] geo;
      logic [2:0]         neg;
      logic               degen;
      logic               use_dist;
   } side_type;

   logic                   en;

   logic [DIV_STEPS-1:0]   dv_vld_ff;
   logic [REM_W-1:0]       rem_ff [DIV_STEPS][3];
   logic [QUO_W-1:0]       quo_ff [DIV_STEPS][3];
   logic [SUM_W-1:0]       den_ff [DIV_STEPS];
   side_type               dv_side_ff [DIV_STEPS];
   logic [REM_W-1:0]       rem_in [DIV_STEPS][3];
   logic [QUO_W-1:0]       quo_in [DIV_STEPS][3];

   logic [SQRT_STEPS-1:0]  sq_vld_ff;
   logic [ROOT_W-1:0]      sx_ff [SQRT_STEPS][3];
   logic [ROOT_W-1:0]      sr_ff [SQRT_STEPS][3];
   side_type               sq_side_ff [SQRT_STEPS];
   logic [ROOT_W-1:0]      sx_in [SQRT_STEPS][3];
   logic [ROOT_W-1:0]      sr_in [SQRT_STEPS][3];

   logic [2:0]             tail_vld_ff;
   logic signed [UNIT_W-1:0] u_ff [3];
   logic signed [UNIT_W-1:0] u2_ff [3];
   logic signed [UNIT_W-1:0] u3_ff [3];
   logic signed [UNIT_W-1:0] u_in [3];
   side_type               u_side_ff, p_side_ff, a_side_ff;
   logic signed [PRW-1:0]  pr_ff [3];
   logic signed [AW-1:0]   acc_ff;
   logic signed [AW-1:0]   acc_in;

   logic                   rsp_valid_ff;
   logic [2:0][UNIT_W-1:0] rsp_unit_ff, rsp_unit_in;
   logic [CW-1:0]          rsp_dist_ff, rsp_dist_in;
   logic                   rsp_degen_ff;
   logic                   acc_neg;
   logic [AW-1:0]          acc_mag;
   logic [MW-1:0]          acc_q;
   logic [CW-1:0]          dist_mag;

   side_type               side_in;

   // the whole back advances unless a result word sits unclaimed
   assign en        = !rsp_valid_ff || rsp_ready;
   assign in_pop    = en && in_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_unit  = rsp_unit_ff;
   assign rsp_dist  = rsp_dist_ff;
   assign rsp_degen = rsp_degen_ff;

   assign side_in = '{geo: in_geo, neg: in_norm.neg, degen: in_norm.degen,
                      use_dist: in_norm.use_dist};

   // quotient sq * 2^60 / ssum, one bit per stage, top bit first
   always_comb begin
      logic [REM_W:0] step;
      for (int l = 0; l < 3; l++) begin
         if (SUM_W'(in_norm.sq[l]) >= in_norm.ssum) begin
            rem_in[0][l] = REM_W'(SUM_W'(in_norm.sq[l]) - in_norm.ssum);
            quo_in[0][l] = QUO_W'(1);
         end else begin
            rem_in[0][l] = REM_W'(in_norm.sq[l]);
            quo_in[0][l] = '0;
         end
      end
      for (int t = 1; t < DIV_STEPS; t++) begin
         for (int l = 0; l < 3; l++) begin
            step         = div_step(rem_ff[t-1][l], den_ff[t-1]);
            rem_in[t][l] = step[REM_W-1:0];
            quo_in[t][l] = {quo_ff[t-1][l][QUO_W-2:0], step[REM_W]};
         end
      end
   end

   // integer square root, one root bit per stage
   always_comb begin
      logic [2*ROOT_W-1:0] step;
      for (int l = 0; l < 3; l++) begin
         step = sqrt_step(ROOT_W'(quo_ff[DIV_STEPS-1][l]), '0,
                          ROOT_W'(1) << (2 * (SQRT_STEPS - 1)));
         sx_in[0][l] = step[2*ROOT_W-1:ROOT_W];
         sr_in[0][l] = step[ROOT_W-1:0];
      end
      for (int s = 1; s < SQRT_STEPS; s++) begin
         for (int l = 0; l < 3; l++) begin
            step = sqrt_step(sx_ff[s-1][l], sr_ff[s-1][l],
                             ROOT_W'(1) << (2 * (SQRT_STEPS - 1 - s)));
            sx_in[s][l] = step[2*ROOT_W-1:ROOT_W];
            sr_in[s][l] = step[ROOT_W-1:0];
         end
      end
   end

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         if (sq_side_ff[SQRT_STEPS-1].neg[l]) begin
            u_in[l] = UNIT_W'(0) - UNIT_W'(sr_ff[SQRT_STEPS-1][l]);
         end else begin
            u_in[l] = UNIT_W'(sr_ff[SQRT_STEPS-1][l]);
         end
      end
      acc_in = AW'(pr_ff[0]) + AW'(pr_ff[1]) + AW'(pr_ff[2]);
   end

   // truncate toward zero by 2^30, then clamp to the coordinate range
   always_comb begin
      acc_neg  = acc_ff[AW-1];
      acc_mag  = acc_neg ? AW'(0) - AW'(acc_ff) : AW'(acc_ff);
      acc_q    = acc_mag[AW-1:UNIT_FRAC];
      if (acc_q > DMAX) begin
         dist_mag = acc_neg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end else begin
         dist_mag = acc_neg ? CW'(0) - acc_q[CW-1:0] : acc_q[CW-1:0];
      end
      if (a_side_ff.degen) begin
         rsp_unit_in = '0;
         rsp_dist_in = '0;
      end else begin
         for (int l = 0; l < 3; l++) rsp_unit_in[l] = u3_ff[l];
         rsp_dist_in = a_side_ff.use_dist ? a_side_ff.geo[3] : dist_mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff    <= '0;
         sq_vld_ff    <= '0;
         tail_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         dv_vld_ff    <= {dv_vld_ff[DIV_STEPS-2:0], in_valid};
         sq_vld_ff    <= {sq_vld_ff[SQRT_STEPS-2:0], dv_vld_ff[DIV_STEPS-1]};
         tail_vld_ff  <= {tail_vld_ff[1:0], sq_vld_ff[SQRT_STEPS-1]};
         rsp_valid_ff <= tail_vld_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff        <= rem_in;
         quo_ff        <= quo_in;
         den_ff[0]     <= in_norm.ssum;
         dv_side_ff[0] <= side_in;
         for (int t = 1; t < DIV_STEPS; t++) begin
            den_ff[t]     <= den_ff[t-1];
            dv_side_ff[t] <= dv_side_ff[t-1];
         end
         sx_ff         <= sx_in;
         sr_ff         <= sr_in;
         sq_side_ff[0] <= dv_side_ff[DIV_STEPS-1];
         for (int s = 1; s < SQRT_STEPS; s++) sq_side_ff[s] <= sq_side_ff[s-1];
         u_ff      <= u_in;
         u_side_ff <= sq_side_ff[SQRT_STEPS-1];
         for (int l = 0; l < 3; l++) begin
            pr_ff[l] <= $signed(u_side_ff.geo[l]) * u_ff[l];
         end
         u2_ff     <= u_ff;
         p_side_ff <= u_side_ff;
         acc_ff    <= acc_in;
         u3_ff     <= u2_ff;
         a_side_ff <= p_side_ff;
         rsp_unit_ff  <= rsp_unit_in;
         rsp_dist_ff  <= rsp_dist_in;
         rsp_degen_ff <= a_side_ff.degen;
      end
   end

`ifndef NO_ASSERTIONS
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_degen_ff |-> rsp_unit_ff == '0 && rsp_dist_ff == '0)
      else $error("degenerate result carries nonzero data");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         ($signed(rsp_unit_ff[0]) <= 32'sd1073741824)
      && ($signed(rsp_unit_ff[0]) >= -32'sd1073741824)
      && ($signed(rsp_unit_ff[1]) <= 32'sd1073741824)
      && ($signed(rsp_unit_ff[1]) >= -32'sd1073741824)
      && ($signed(rsp_unit_ff[2]) <= 32'sd1073741824)
      && ($signed(rsp_unit_ff[2]) >= -32'sd1073741824))
      else $error("unit normal component out of range");

   a_unit_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_degen_ff |-> rsp_unit_ff != '0)
      else $error("regular plane produced a zero normal");

   a_pop_needs_data: assert property (@(posedge clock) disable iff (reset)
      in_pop |-> in_valid)
      else $error("queue popped while empty");
`endif

endmodule
`default_nettype wire

>>> test/plane_from_points_normalizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plane_from_points_normalizer_tb
// Drives normal+distance, normal+point, three-point and undefined requests
// with random gaps and result back-pressure, predicts every plane word in
// exact wide arithmetic and compares unit normal, distance and degenerate flag.
// ----------------------------------------------------------------------------
module plane_from_points_normalizer_tb;
   import pfpn_pkg::*;

   localparam int CW = 32;
   localparam int REQ_W = ((10*CW+7)/8)*8;
   localparam int RSP_W = ((3*UNIT_W+CW+7)/8)*8;
   localparam int N_RANDOM = 1830;
   localparam int DRAIN_CYCLES = 300;

   // one request word: coordinate fields in tdata order plus the request kind
   typedef struct {
      logic [1:0]        kind;
      logic [9:0][31:0]  coord;
      bit                drain_first;   // hold until every plane is back
   } plane_req_type;

   typedef struct {
      logic signed [31:0] ux, uy, uz, plane_dist;
      logic               degen;
   } plane_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic rsp_tuser;

   plane_req_type pending_q[$];
   plane_rsp_type plane_q[$];
   int mismatches = 0;
   bit req_taken = 0;
   bit rsp_taken = 0;
   int req_gap = 0;
   int rsp_stall = 0;
   logic [1:0] cur_kind;
   logic [9:0][31:0] cur_coord;

   plane_from_points_normalizer #(.COORD_WIDTH(CW)) i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata),   // vec_a_x..z, vec_b_x..z, vec_c_x..z, in_distance
      .req_tuser(req_tuser),   // req_type
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),   // unit_x, unit_y, unit_z, plane_distance
      .rsp_tuser(rsp_tuser)    // degenerate
   );

   always #5 clock = ~clock;

   // integer square root, floor
   function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
      logic [63:0] res, wt, rem;
      res = 0;
      rem = x;
      wt = 64'd1 << 62;
      while (wt > rem) wt = wt >> 2;
      while (wt != 0) begin
         if (rem >= res + wt) begin
            rem = rem - (res + wt);
            res = (res >> 1) + wt;
         end else begin
            res = res >> 1;
         end
         wt = wt >> 2;
      end
      return res;
   endfunction

   // exact plane: unit normal in Q1.30 and saturated Q16.16 distance
   function automatic plane_rsp_type plane_of(input logic [1:0] kind,
                                              input logic [9:0][31:0] c);
      logic signed [127:0] a[3], b[3], p3[3], e[3], g[3], nrm[3], pt[3], uw, acc;
      logic [127:0] sq[3], ssum, q, mag;
      logic signed [31:0] u[3];
      bit fits, neg;
      plane_rsp_type r;
      r = '{default: '0};
      if (kind == MODE_NONE) begin
         r.degen = 1'b1;
         return r;
      end
      for (int i = 0; i < 3; i++) begin
         a[i] = $signed(c[i]);
         b[i] = $signed(c[3+i]);
         p3[i] = $signed(c[6+i]);
      end
      if (kind == MODE_TRI) begin
         for (int i = 0; i < 3; i++) begin
            e[i] = b[i] - a[i];
            g[i] = p3[i] - a[i];
            pt[i] = a[i];
         end
         nrm[0] = e[1]*g[2] - e[2]*g[1];
         nrm[1] = e[2]*g[0] - e[0]*g[2];
         nrm[2] = e[0]*g[1] - e[1]*g[0];
      end else begin
         for (int i = 0; i < 3; i++) begin
            nrm[i] = a[i];
            pt[i] = b[i];
         end
      end
      if (nrm[0] == 0 && nrm[1] == 0 && nrm[2] == 0) begin
         r.degen = 1'b1;
         return r;
      end
      // shrink all three together until each fits in [-2^30, 2^30)
      fits = 0;
      while (!fits) begin
         fits = 1;
         for (int i = 0; i < 3; i++)
            if (nrm[i] >= 128'sh40000000 || nrm[i] < -128'sh40000000) fits = 0;
         if (!fits)
            for (int i = 0; i < 3; i++) nrm[i] = nrm[i] >>> 1;
      end
      ssum = 0;
      for (int i = 0; i < 3; i++) begin
         sq[i] = nrm[i] * nrm[i];
         ssum = ssum + sq[i];
      end
      for (int i = 0; i < 3; i++) begin
         q = (sq[i] << 60) / ssum;
         u[i] = 32'(floor_sqrt(q[63:0]));
         if (nrm[i] < 0) u[i] = -u[i];
      end
      r.ux = u[0];
      r.uy = u[1];
      r.uz = u[2];
      if (kind == MODE_DIST) begin
         r.plane_dist = c[9];
      end else begin
         acc = 0;
         for (int i = 0; i < 3; i++) begin
            uw = u[i];
            acc = acc + pt[i] * uw;
         end
         neg = acc < 0;
         mag = neg ? -acc : acc;
         mag = mag >> 30;
         if (mag > 128'h7FFFFFFF) r.plane_dist = neg ? 32'sh80000000 : 32'sh7FFFFFFF;
         else r.plane_dist = neg ? -32'(mag) : 32'(mag);
      end
      return r;
   endfunction

   function automatic logic [31:0] any_coord();
      logic [31:0] v;
      case ($urandom_range(0, 4))
         0: v = $urandom;
         1: v = $urandom_range(0, 1 << 20) - (1 << 19);
         2: v = $urandom_range(0, 1 << 26) - (1 << 25);
         3: begin
            case ($urandom_range(0, 3))
               0: v = 32'h80000000;
               1: v = 32'h7FFFFFFF;
               2: v = 32'h0;
               default: v = 32'hFFFFFFFF;
            endcase
         end
         default: v = $urandom_range(0, 16) - 8;
      endcase
      return v;
   endfunction

   function automatic plane_req_type random_req();
      plane_req_type it;
      int k;
      it.drain_first = 0;
      for (int i = 0; i < 10; i++) it.coord[i] = any_coord();
      k = $urandom_range(0, 19);
      it.kind = (k == 0) ? MODE_NONE : (k < 7) ? MODE_DIST : (k < 13) ? MODE_POINT : MODE_TRI;
      // now and then make the three points collinear, or the normal zero
      if (it.kind == MODE_TRI && $urandom_range(0, 9) == 0) begin
         for (int i = 0; i < 3; i++) begin
            it.coord[i] = $urandom_range(0, 1 << 16) - (1 << 15);
            it.coord[3+i] = it.coord[i] + ($urandom_range(0, 64) - 32);
            it.coord[6+i] = it.coord[i] + 3 * (it.coord[3+i] - it.coord[i]);
         end
      end else if (it.kind != MODE_TRI && $urandom_range(0, 19) == 0) begin
         it.coord[0] = 0;
         it.coord[1] = 0;
         it.coord[2] = 0;
      end
      return it;
   endfunction

   task automatic add_req(input logic [1:0] kind,
                          input logic [31:0] ax, ay, az, bx, by, bz, cx, cy, cz, d);
      plane_req_type it;
      it.kind = kind;
      it.coord = {d, cz, cy, cx, bz, by, bx, az, ay, ax};
      it.drain_first = 0;
      pending_q.push_back(it);
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch %s: expected %h, got %h at %0t", name, want, got, $time);
      end
   endtask

   // stimulus: directed corners first, then random words
   initial begin
      plane_req_type it;
      add_req(MODE_DIST, 32'h10000, 0, 0, 0, 0, 0, 0, 0, 0, 32'h7FFFFFFF);
      add_req(MODE_DIST, 0, 0, 32'hFFFF0000, 0, 0, 0, 0, 0, 0, 32'h80000000);
      add_req(MODE_DIST, 0, 0, 0, 5, 6, 7, 8, 9, 10, 32'h1234);
      add_req(MODE_DIST, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 0, 0, 0, 1);
      add_req(MODE_DIST, 32'h7FFFFFFF, 32'h80000000, 1, 0, 0, 0, 0, 0, 0, 0);
      add_req(MODE_DIST, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, '1, '1, '1, '1, '1, '1, '1);
      add_req(MODE_POINT, 32'h10000, 0, 0, 32'h7FFFFFFF, 0, 0, 0, 0, 0, 0);
      add_req(MODE_POINT, 1, 1, 1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0, 0);
      add_req(MODE_POINT, 1, 1, 1, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 0);
      add_req(MODE_POINT, 0, 0, 0, 32'h10000, 32'h20000, 32'h30000, 0, 0, 0, 0);
      add_req(MODE_POINT, 32'h30000, 32'hFFFC0000, 0, 32'h50000, 32'h10000, 32'h80000000, 0, 0, 0, 0);
      add_req(MODE_TRI, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0, 0);
      add_req(MODE_TRI, 32'h80000000, 32'h80000000, 32'h80000000,
              32'h7FFFFFFF, 32'h80000000, 32'h80000000,
              32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0);
      add_req(MODE_TRI, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
              32'h80000000, 32'h7FFFFFFF, 32'h80000000,
              32'h7FFFFFFF, 32'h80000000, 32'h80000000, 0);
      add_req(MODE_TRI, 5, 6, 7, 5, 6, 7, 9, 9, 9, 0);
      add_req(MODE_TRI, 0, 0, 0, 1, 2, 3, 2, 4, 6, 0);
      add_req(MODE_TRI, 32'h10000, 32'h20000, 32'h30000, 32'h10001, 32'h20000, 32'h30000,
              32'h10000, 32'h20001, 32'h30000, 0);
      add_req(MODE_NONE, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1);
      add_req(MODE_NONE, 32'h10000, 0, 0, 0, 0, 0, 0, 0, 0, 5);
      for (int n = 0; n < N_RANDOM; n++) begin
         it = random_req();
         if (n == 0 || n == N_RANDOM / 2) it.drain_first = 1;
         pending_q.push_back(it);
      end
   end

   // reset, then wait for the stream to drain and report
   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      wait (pending_q.size() == 0 && !req_tvalid);
      wait (plane_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && plane_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("TEST FAILED");
      $finish;
   end

   // sample both handshakes at the edge; predict each accepted request
   always @(posedge clock) begin
      plane_rsp_type want;
      req_taken = req_tvalid && req_tready;
      rsp_taken = rsp_tvalid && rsp_tready;
      if (!reset && req_taken) plane_q.push_back(plane_of(req_tuser, req_tdata[319:0]));
      if (!reset && rsp_taken) begin
         if (plane_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected plane word at %0t", $time);
         end else begin
            want = plane_q.pop_front();
            check_field("unit_x", want.ux, rsp_tdata[31:0]);
            check_field("unit_y", want.uy, rsp_tdata[63:32]);
            check_field("unit_z", want.uz, rsp_tdata[95:64]);
            check_field("distance", want.plane_dist, rsp_tdata[127:96]);
            check_field("degenerate", 32'(want.degen), 32'(rsp_tuser));
         end
      end
   end

   // request driver: hold a word until taken, then idle for its drawn gap
   always @(negedge clock) begin
      logic next_valid;
      next_valid = req_tvalid && !req_taken;
      if (!reset && !next_valid) begin
         if (req_gap > 0) begin
            req_gap--;
         end else if (pending_q.size() != 0 &&
                      !(pending_q[0].drain_first && plane_q.size() != 0)) begin
            cur_kind = pending_q[0].kind;
            cur_coord = pending_q[0].coord;
            void'(pending_q.pop_front());
            req_tdata <= cur_coord;
            req_tuser <= cur_kind;
            next_valid = 1'b1;
            // long bursts with no gap now and then
            req_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
         end
      end
      req_tvalid <= next_valid;
   end

   // result back-pressure: hold rsp_tready low for a drawn stall after each word
   always @(negedge clock) begin
      if (rsp_taken || reset) rsp_stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      else if (rsp_stall > 0) rsp_stall--;
      rsp_tready <= !reset && rsp_stall == 0;
   end

endmodule
